>>> src/vfc_pkg.sv
// shared types and constants for the view frustum culling block
// no dependencies
package vfc_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int NUM_PLANES        = 6;
  localparam int PLANE_W           = 3;
  localparam int COL_W             = 2;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_W             = 64;

  // test kinds
  localparam logic [1:0] OP_POINT  = 2'd0;
  localparam logic [1:0] OP_SPHERE = 2'd1;
  localparam logic [1:0] OP_BOX    = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [30:0]        sphere_radius;
  } in_beat_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate_plane;
  } out_beat_t;

  typedef struct packed {
    logic               item_load;
    logic               marks_clr;
    logic               sq_step;
    logic               sq_first;
    logic               rt_init;
    logic               rt_step;
    logic               dv_init;
    logic               dv_step;
    logic               cf_write;
    logic               ts_mul;
    logic               ts_acc;
    logic               out_load;
    logic [PLANE_W-1:0] plane;
    logic [COL_W-1:0]   col;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

>>> src/view_frustum_culling.sv
// view frustum culling: top level joining controller and datapath
// depends on vfc_pkg, vfc_ctrl, vfc_dp
//
// Tests a point, sphere or axis-aligned box against the six clip planes
// of a 4x4 matrix held in eight 64-bit registers (two signed fixed-point
// entries each, low column in the low half; reset gives identity). After
// any register write the first item rebuilds the planes: per plane three
// squares, a square root at one bit per cycle and four restoring divides
// of 33 + FRACTION_BITS steps each, with a load before and a store after
// each divide. With the planes built an item is accepted, then each plane
// gets a product step and a sum-and-compare step, and the result is posted
// once the output register is free. The input stalls while an item is
// in work; a finished beat waits in the output register while the next
// item is accepted. A plane with a zero-length normal never rejects and
// sets degenerate_plane on every result until the matrix changes.

module view_frustum_culling import vfc_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // item input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_data_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer for plane build and tests
  vfc_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic, plane store and result register
  vfc_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> src/vfc_dp.sv
// datapath: matrix registers, plane build (squares, square root, divide),
// plane store and per-plane distance test; depends on vfc_pkg
module vfc_dp import vfc_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  in_beat_t             in_data_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output out_beat_t            out_data_o
);

  localparam int DIV_STEPS = 33 + FRACTION_BITS;

  logic [7:0][CFG_W-1:0] mat_q;
  in_beat_t              item_q;

  // matrix registers, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= {64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
                64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000};
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) item_q <= in_data_i;
  end

  // plane element: row 3 plus or minus row p/2
  logic [63:0]        r3, rr;
  logic [31:0]        w3, wr;
  logic signed [32:0] v;
  logic [32:0]        mag;
  always_comb begin
    r3  = mat_q[{2'b11, cmd_i.col[1]}];
    rr  = mat_q[{cmd_i.plane[2:1], cmd_i.col[1]}];
    w3  = cmd_i.col[0] ? r3[63:32] : r3[31:0];
    wr  = cmd_i.col[0] ? rr[63:32] : rr[31:0];
    v   = cmd_i.plane[0] ? ($signed({w3[31], w3}) + $signed({wr[31], wr}))
                         : ($signed({w3[31], w3}) - $signed({wr[31], wr}));
    mag = v[32] ? 33'(-v) : 33'(v);
  end

  // sum of squares
  logic [65:0] prod_q;
  logic [67:0] sum_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_step) begin
      prod_q <= mag * mag;
      sum_q  <= cmd_i.sq_first ? '0 : sum_q + 68'(prod_q);
    end
  end

  // square root, one result bit per step
  logic [67:0] rad_q;
  logic [36:0] rem_q, rem_sh, trial;
  logic [33:0] root_q;
  logic        rt_ge;
  always_comb begin
    rem_sh = {rem_q[34:0], rad_q[67:66]};
    trial  = 37'({root_q, 2'b01});
    rt_ge  = rem_sh >= trial;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.rt_init) begin
      rad_q  <= sum_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.rt_step) begin
      rad_q  <= {rad_q[65:0], 2'b00};
      rem_q  <= rt_ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[32:0], rt_ge};
    end
  end

  // restoring divide of |v| << fraction bits by the root
  logic [DIV_STEPS-1:0] dq_q;
  logic [33:0]          drem_q;
  logic                 neg_q;
  logic [34:0]          dsh;
  logic                 dv_ge;
  always_comb begin
    dsh   = {drem_q, dq_q[DIV_STEPS-1]};
    dv_ge = dsh >= 35'(root_q);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.dv_init) begin
      dq_q   <= DIV_STEPS'(mag) << FRACTION_BITS;
      drem_q <= '0;
      neg_q  <= v[32];
    end else if (cmd_i.dv_step) begin
      drem_q <= dv_ge ? 34'(dsh - 35'(root_q)) : dsh[33:0];
      dq_q   <= {dq_q[DIV_STEPS-2:0], dv_ge};
    end
  end

  // saturate quotient to 32-bit signed
  logic [31:0] coef_sat;
  always_comb begin
    if (neg_q) begin
      if ((|dq_q[DIV_STEPS-1:32]) || (dq_q[31] && (|dq_q[30:0])))
        coef_sat = 32'h8000_0000;
      else
        coef_sat = 32'(-dq_q[31:0]);
    end else begin
      coef_sat = (|dq_q[DIV_STEPS-1:31]) ? 32'h7fff_ffff : dq_q[31:0];
    end
  end

  // plane store, one row of a b c d per plane
  logic [3:0][31:0] coef_q [NUM_PLANES];
  logic [NUM_PLANES-1:0] marks_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cf_write) coef_q[cmd_i.plane][cmd_i.col] <= coef_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
    end else if (cmd_i.marks_clr) begin
      marks_q <= '0;
    end else if (cmd_i.dv_init) begin
      marks_q[cmd_i.plane] <= (root_q == '0);
    end
  end

  // distance test
  logic [3:0][31:0]   row;
  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];
  logic signed [31:0] xs [3];
  logic signed [63:0] tp_q [3];
  logic signed [31:0] d_q;
  always_comb begin
    row   = coef_q[cmd_i.plane];
    lo[0] = item_q.first_x;  lo[1] = item_q.first_y;  lo[2] = item_q.first_z;
    hi[0] = item_q.second_x; hi[1] = item_q.second_y; hi[2] = item_q.second_z;
    for (int j = 0; j < 3; j++) begin
      xs[j] = (item_q.opcode == OP_BOX && $signed(row[j]) > 0) ? hi[j] : lo[j];
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.ts_mul) begin
      for (int j = 0; j < 3; j++) tp_q[j] <= $signed(row[j]) * xs[j];
      d_q <= $signed(row[3]);
    end
  end

  logic signed [67:0] pdist, rad_lim;
  logic               reject;
  always_comb begin
    pdist = 68'(tp_q[0]) + 68'(tp_q[1]) + 68'(tp_q[2])
          + (68'(d_q) <<< FRACTION_BITS);
    rad_lim = -($signed(68'(item_q.sphere_radius)) <<< FRACTION_BITS);
    if (marks_q[cmd_i.plane])
      reject = 1'b0;
    else if (item_q.opcode == OP_SPHERE)
      reject = pdist <= rad_lim;
    else
      reject = pdist < 0;
  end

  logic inside_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load)   inside_q <= 1'b1;
    else if (cmd_i.ts_acc) inside_q <= inside_q & ~reject;
  end

  // result register
  logic      out_valid_q;
  out_beat_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.inside_res       <= inside_q;
      out_q.degenerate_plane <= |marks_q;
    end
  end

  assign sts_o.out_busy = out_valid_q & out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

>>> src/vfc_ctrl.sv
// controller: sequences plane build and the six plane tests
// depends on vfc_pkg
module vfc_ctrl import vfc_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam int DIV_STEPS = 33 + FRACTION_BITS;
  localparam int RT_STEPS  = 34;
  localparam int SQ_STEPS  = 4;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_RINIT = 4'd2;
  localparam logic [3:0] S_RT    = 4'd3;
  localparam logic [3:0] S_DINIT = 4'd4;
  localparam logic [3:0] S_DV    = 4'd5;
  localparam logic [3:0] S_DWR   = 4'd6;
  localparam logic [3:0] S_TMUL  = 4'd7;
  localparam logic [3:0] S_TACC  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(NUM_PLANES - 1);
  localparam logic [COL_W-1:0]   LAST_COL   = '1;

  logic [3:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic               ready_q, ready_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    plane_d = plane_q;
    col_d   = col_q;
    ready_d = ready_q;
    cmd_o   = '0;
    cmd_o.plane = plane_q;
    cmd_o.col   = col_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          plane_d = '0;
          col_d   = '0;
          cnt_d   = '0;
          if (ready_q) begin
            state_d = S_TMUL;
          end else begin
            cmd_o.marks_clr = 1'b1;
            state_d = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd_o.sq_step  = 1'b1;
        cmd_o.sq_first = (cnt_q == '0);
        cmd_o.col      = cnt_q[COL_W-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQ_STEPS - 1)) state_d = S_RINIT;
      end
      S_RINIT: begin
        cmd_o.rt_init = 1'b1;
        cnt_d   = '0;
        state_d = S_RT;
      end
      S_RT: begin
        cmd_o.rt_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(RT_STEPS - 1)) begin
          col_d   = '0;
          state_d = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd_o.dv_init = 1'b1;
        cnt_d   = '0;
        state_d = S_DV;
      end
      S_DV: begin
        cmd_o.dv_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_DWR;
      end
      S_DWR: begin
        cmd_o.cf_write = 1'b1;
        if (col_q == LAST_COL) begin
          cnt_d = '0;
          col_d = '0;
          if (plane_q == LAST_PLANE) begin
            ready_d = 1'b1;
            plane_d = '0;
            state_d = S_TMUL;
          end else begin
            plane_d = plane_q + 1'b1;
            state_d = S_SQ;
          end
        end else begin
          col_d   = col_q + 1'b1;
          state_d = S_DINIT;
        end
      end
      S_TMUL: begin
        cmd_o.ts_mul = 1'b1;
        state_d = S_TACC;
      end
      S_TACC: begin
        cmd_o.ts_acc = 1'b1;
        if (plane_q == LAST_PLANE) begin
          state_d = S_DONE;
        end else begin
          plane_d = plane_q + 1'b1;
          state_d = S_TMUL;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) ready_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      plane_q <= '0;
      col_q   <= '0;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      plane_q <= plane_d;
      col_q   <= col_d;
      ready_q <= ready_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> tb/view_frustum_culling_test.sv
// self-checking testbench for the view frustum culling block
// depends on vfc_pkg and view_frustum_culling; a built-in plane predictor or a directed expectation checks each result
module view_frustum_culling_test;
  import vfc_pkg::*;

  localparam int FRAC = FRACTION_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;

  // directed stimulus row; want_* only meaningful when typed is set
  typedef struct {
    logic [1:0]  op;
    logic [31:0] ax, ay, az, bx, by, bz;
    logic [30:0] rad;
    bit          typed;
    bit          want_inside, want_degen;
  } probe_row_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  in_beat_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  out_beat_t   out_data_o;

  view_frustum_culling i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state: matrix copy, derived planes, zero-normal marks
  logic [63:0] mat_regs[8];
  longint      plane_k[24];
  logic [5:0]  flat_marks;
  bit          planes_valid;

  out_beat_t   pending_verdicts[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          calm = 0;      // no idling on either side
  bit          hold_long = 0; // receiver holds off for a long stretch

  function automatic longint mat_entry(int row, int col);
    logic [63:0] r;
    logic [31:0] h;
    r = mat_regs[row * 2 + col / 2];
    h = (col % 2) ? r[63:32] : r[31:0];
    return longint'($signed(h));
  endfunction

  function automatic void build_clip_planes();
    longint      v[4];
    logic [69:0] acc, c;
    logic [33:0] root;
    logic [63:0] mag;
    longint      q;
    flat_marks = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int j = 0; j < 4; j++)
        v[j] = (p % 2) ? mat_entry(3, j) + mat_entry(p / 2, j)
                       : mat_entry(3, j) - mat_entry(p / 2, j);
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        mag = (v[j] < 0) ? -v[j] : v[j];
        acc += 70'(mag) * 70'(mag);
      end
      // floor square root, one bit at a time
      root = '0;
      for (int b = 33; b >= 0; b--) begin
        c = 70'(root | (34'd1 << b));
        if (c * c <= acc) root = c[33:0];
      end
      for (int j = 0; j < 4; j++) begin
        q = 0;
        if (root != 0) begin
          q = (v[j] * (longint'(1) << FRAC)) / longint'(root);
          if (q > 64'sd2147483647) q = 64'sd2147483647;
          if (q < -64'sd2147483648) q = -64'sd2147483648;
        end
        plane_k[p * 4 + j] = q;
      end
      if (root == 0) flat_marks[p] = 1'b1;
    end
    planes_valid = 1;
  endfunction

  function automatic out_beat_t cull_verdict(in_beat_t it);
    out_beat_t res;
    longint lo[3], hi[3], pdist, k;
    longint rad;
    if (!planes_valid) build_clip_planes();
    lo[0] = it.first_x;  lo[1] = it.first_y;  lo[2] = it.first_z;
    hi[0] = it.second_x; hi[1] = it.second_y; hi[2] = it.second_z;
    rad = longint'(it.sphere_radius);
    res.inside_res = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (!flat_marks[p]) begin
        pdist = plane_k[p * 4 + 3] * (longint'(1) << FRAC);
        for (int j = 0; j < 3; j++) begin
          k = plane_k[p * 4 + j];
          pdist += k * ((it.opcode == OP_BOX && k > 0) ? hi[j] : lo[j]);
        end
        if (it.opcode == OP_SPHERE) begin
          if (pdist <= -(rad * (longint'(1) << FRAC))) res.inside_res = 1'b0;
        end else if (pdist < 0) begin
          res.inside_res = 1'b0;
        end
      end
    end
    res.degenerate_plane = |flat_marks;
    return res;
  endfunction

  // one beat on the input side, expectation queued at acceptance
  task automatic send_item(in_beat_t it, bit typed, out_beat_t typed_res);
    int gap;
    out_beat_t pred;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = cull_verdict(it);
    pending_verdicts.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // writes a whole matrix while the block is idle
  task automatic load_matrix(logic [63:0] m[8]);
    drain_results();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= m[i];
      @(posedge clk_i);
      mat_regs[i] = m[i];
      planes_valid = 0;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] coord_draw();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
  endfunction

  function automatic logic [31:0] entry_draw(bit full);
    if (full) return $urandom();
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic in_beat_t item_draw();
    in_beat_t it;
    it.opcode   = 2'($urandom_range(0, 3));
    it.first_x  = coord_draw();
    it.first_y  = coord_draw();
    it.first_z  = coord_draw();
    it.second_x = coord_draw();
    it.second_y = coord_draw();
    it.second_z = coord_draw();
    it.sphere_radius = ($urandom_range(0, 7) == 0) ? 31'($urandom())
                                                  : 31'($urandom_range(0, 32'h0004_0000));
    return it;
  endfunction

  task automatic random_batch(int n);
    out_beat_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send_item(item_draw(), 0, none);
    end
    calm = 0;
  endtask

  // receiver: random stalls, occasional long hold-off, checks each beat
  initial begin
    int n;
    out_beat_t want;
    forever begin
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_long = 0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 11);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat %b", $time, out_data_o);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data_o.inside_res !== want.inside_res) begin
          $display("%0t: inside_res expected %b actual %b",
                   $time, want.inside_res, out_data_o.inside_res);
          error_count++;
        end
        if (out_data_o.degenerate_plane !== want.degenerate_plane) begin
          $display("%0t: degenerate_plane expected %b actual %b",
                   $time, want.degenerate_plane, out_data_o.degenerate_plane);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("view_frustum_culling_test: errors");
      $finish;
    end
  end

  initial begin
    probe_row_t probes[$];
    logic [63:0] m[8];
    in_beat_t it;
    out_beat_t tr;

    // identity after reset
    mat_regs[0] = 64'd65536; mat_regs[1] = 0;
    mat_regs[2] = 64'd65536 << 32; mat_regs[3] = 0;
    mat_regs[4] = 0; mat_regs[5] = 64'd65536;
    mat_regs[6] = 0; mat_regs[7] = 64'd65536 << 32;
    planes_valid = 0;
    flat_marks = '0;

    // identity planes bound the unit cube
    probes = '{
      '{OP_POINT,  0, 0, 0, 0, 0, 0, 0, 1, 1, 0},
      '{OP_POINT,  32'h0002_0000, 0, 0, 0, 0, 0, 0, 1, 0, 0},
      '{OP_POINT,  ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0, 1, 1, 0},
      '{OP_POINT,  32'h8000_0000, 0, 0, 0, 0, 0, 0, 1, 0, 0},
      '{OP_POINT,  0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, 0, 0},
      '{OP_SPHERE, 32'h0002_0000, 0, 0, 0, 0, 0, 31'h0001_8000, 1, 1, 0},
      '{OP_SPHERE, 32'h0002_0000, 0, 0, 0, 0, 0, 31'h0001_0000, 1, 0, 0},
      '{OP_SPHERE, 0, 0, 32'h8000_0000, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0},
      '{OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{OP_BOX, 32'h0002_0000, 0, 0, 32'h0003_0000, 0, 0, 0, 1, 0, 0},
      '{OP_BOX, 32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000,
                32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 0, 1, 1, 0},
      '{OP_BOX, 32'h0002_0000, 0, 0, 32'hFFFE_0000, 0, 0, 0, 0, 0, 0},
      '{OP_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0},
      '{2'd3, 32'h0002_0000, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 1, 0, 0},
      '{2'd3, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1, 0},
      '{OP_POINT, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                31'h7FFF_FFFF, 1, 1, 0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      it = '{probes[i].op, probes[i].ax, probes[i].ay, probes[i].az,
             probes[i].bx, probes[i].by, probes[i].bz, probes[i].rad};
      tr = '{probes[i].want_inside, probes[i].want_degen};
      send_item(it, probes[i].typed, tr);
    end

    // zero matrix: every plane flat, nothing rejected
    foreach (m[i]) m[i] = '0;
    load_matrix(m);
    send_item('{OP_POINT, 32'h8000_0000, 0, 0, 0, 0, 0, 0}, 1, '{1'b1, 1'b1});
    send_item('{OP_SPHERE, 0, 32'h8000_0000, 0, 0, 0, 0, 0}, 1, '{1'b1, 1'b1});
    send_item('{OP_BOX, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0}, 1, '{1'b1, 1'b1});
    random_batch(15);

    // extreme entries: row 3 at max, other rows at min, then all ones
    for (int i = 0; i < 6; i++) m[i] = {32'h8000_0000, 32'h8000_0000};
    m[6] = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
    m[7] = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
    load_matrix(m);
    random_batch(30);
    foreach (m[i]) m[i] = '1;
    load_matrix(m);
    random_batch(20);

    // matrix with one flat plane: row 0 equals row 3 in its first three columns
    foreach (m[i]) m[i] = {entry_draw(0), entry_draw(0)};
    m[0] = m[6];
    m[1][31:0] = m[7][31:0];
    load_matrix(m);
    random_batch(30);

    // moderate random matrices, where culling goes both ways
    for (int ph = 0; ph < 5; ph++) begin
      foreach (m[i]) m[i] = {entry_draw(0), entry_draw(0)};
      load_matrix(m);
      if (ph == 1) hold_long = 1;
      random_batch(50);
      if (ph == 2) drain_results();
    end

    // full-range matrix
    foreach (m[i]) m[i] = {entry_draw(1), entry_draw(1)};
    load_matrix(m);
    random_batch(40);

    // back to identity with a long hold-off
    m[0] = 64'd65536; m[1] = 0; m[2] = 64'd65536 << 32; m[3] = 0;
    m[4] = 0; m[5] = 64'd65536; m[6] = 0; m[7] = 64'd65536 << 32;
    load_matrix(m);
    hold_long = 1;
    random_batch(40);

    drain_results();
    if (error_count == 0)
      $display("view_frustum_culling_test: clean");
    else
      $display("view_frustum_culling_test: errors");
    $finish;
  end

endmodule
